[hw/rtl/aes_block_encrypt_core_assert.svh]
// Assertion macros used by the checker file.
// Included by bare file name.
`ifndef AES_BLOCK_ENCRYPT_CORE_ASSERT_SVH
`define AES_BLOCK_ENCRYPT_CORE_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define AES_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define AES_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

[hw/rtl/aes_pkg.sv]
// AES package: types, S-box and GF helpers.
// No dependencies.
`timescale 1ns / 1ps
package aes_pkg;
  localparam int unsigned BLK_W = 64;
  localparam int unsigned KEY_WORDS = 4;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned RND_W = 4;

  localparam logic [CFG_IDX_W-1:0] REG_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY0 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY1 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY2 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KEY3 = 3'd4;

  localparam logic [1:0] MODE_128 = 2'd0;
  localparam logic [1:0] MODE_192 = 2'd1;

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DONE} state_t;

  // control from sequencer to round unit
  typedef struct packed {
    logic load;
    logic step;
    logic last;
  } rnd_ctl_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] RCON [10] = '{
    8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
  };

  function automatic logic [7:0] xtime(input logic [7:0] v);
    xtime = {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction
endpackage

[hw/rtl/aes_stream_if.sv]
// Valid/ready channel interfaces for block data and configuration.
// Depends on aes_pkg.
`timescale 1ns / 1ps
interface aes_blk_if;
  logic valid;
  logic ready;
  logic [aes_pkg::BLK_W-1:0] data_high;
  logic [aes_pkg::BLK_W-1:0] data_low;
  modport source (output valid, output data_high, output data_low, input ready);
  modport sink (input valid, input data_high, input data_low, output ready);
endinterface

interface aes_cfg_if;
  logic valid;
  logic ready;
  logic [aes_pkg::CFG_IDX_W-1:0] index;
  logic [aes_pkg::BLK_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[hw/rtl/aes_key_sched.sv]
// On-the-fly key schedule: one round key (4 words) per step.
// Depends on aes_pkg. Keeps a sliding window of Nk words.
`timescale 1ns / 1ps
module aes_key_sched (
  input  logic         clk,
  input  logic [1:0]   mode,
  input  logic [255:0] key,
  input  logic         load,
  input  logic         step,
  output logic [127:0] rkey
);
  // win_r holds the 8 most recent words, w[i-1] at [31:0].
  logic [255:0] win_r, win_nxt;
  logic [127:0] rk_r, rk_nxt;
  logic [2:0]   pos_r, pos_nxt;     // idx mod nk
  logic [3:0]   rci_r, rci_nxt;     // rcon index
  logic [255:0] init_win;
  logic [3:0]   nk;

  assign nk = (mode == aes_pkg::MODE_128) ? 4'd4 : (mode == aes_pkg::MODE_192) ? 4'd6 : 4'd8;

  // Window at load: key words packed so newest is in low bits; buffer of pending words.
  // buf holds words ahead of consumption: produce 4 words per step from window+generation.
  logic [31:0] wq [12];   // queue of produced-but-unconsumed words, oldest at 0
  logic [31:0] wq_nxt [12];
  logic [3:0]  qn_r, qn_nxt;

  always_comb begin
    logic [255:0] w;
    logic [2:0]   ps;
    logic [3:0]   rc;
    logic [31:0]  t;
    logic [31:0]  q [12];
    logic [3:0]   n;
    w = win_r; ps = pos_r; rc = rci_r; n = qn_r;
    t = '0;
    for (int k = 0; k < 12; k++) q[k] = wq[k];
    init_win = '0;
    if (load) begin
      // initial window: word j of key at position (nk-1-j) from newest
      for (int j = 0; j < 8; j++) begin
        if (4'(j) < nk) init_win[32*(nk-1-4'(j)) +: 32] = key[255-32*j -: 32];
      end
      w = init_win;
      for (int j = 0; j < 8; j++) q[j] = key[255-32*j -: 32];
      for (int j = 8; j < 12; j++) q[j] = '0;
      n = nk; ps = 3'd0; rc = 4'd0;
    end
    rk_nxt = rk_r;
    if (load || step) begin
      // top up the queue to at least 4 words (at most 4 generated)
      for (int g = 0; g < 4; g++) begin
        if (n < 4'd4 + (load ? 4'd0 : 4'd4)) begin
          t = w[31:0];
          if (ps == 3'd0) begin
            t = aes_pkg::sub_word({t[23:0], t[31:24]}) ^ {aes_pkg::RCON[rc], 24'h0};
            rc = (rc == 4'd9) ? 4'd0 : rc + 4'd1;
          end else if (nk == 4'd8 && ps == 3'd4) begin
            t = aes_pkg::sub_word(t);
          end
          t = t ^ w[32*(nk-1) +: 32];
          w = {w[223:0], t};
          q[n] = t;
          n = n + 4'd1;
          ps = (4'(ps) + 4'd1 == nk) ? 3'd0 : ps + 3'd1;
        end
      end
      rk_nxt = {q[0], q[1], q[2], q[3]};
      for (int k = 0; k < 8; k++) q[k] = q[k+4];
      for (int k = 8; k < 12; k++) q[k] = '0;
      n = n - 4'd4;
    end
    win_nxt = w; pos_nxt = ps; rci_nxt = rc; qn_nxt = n;
    for (int k = 0; k < 12; k++) wq_nxt[k] = q[k];
  end

  always_ff @(posedge clk) begin
    win_r <= win_nxt; pos_r <= pos_nxt; rci_r <= rci_nxt;
    qn_r <= qn_nxt; rk_r <= rk_nxt;
    for (int k = 0; k < 12; k++) wq[k] <= wq_nxt[k];
  end

  assign rkey = rk_nxt;
endmodule

[hw/rtl/aes_round.sv]
// Shared round unit: AddRoundKey on load, full/final round per step.
// Depends on aes_pkg.
`timescale 1ns / 1ps
module aes_round (
  input  logic              clk,
  input  aes_pkg::rnd_ctl_t ctl,
  input  logic [127:0]      blk_in,
  input  logic [127:0]      rkey,
  output logic [127:0]      state
);
  logic [127:0] st_r, st_nxt;
  logic [7:0] sb [16];
  logic [7:0] sr [16];
  logic [7:0] mc [16];
  logic [127:0] rnd_out;

  // SubBytes and ShiftRows; byte i = column i/4, row i%4
  always_comb begin
    for (int i = 0; i < 16; i++) sb[i] = aes_pkg::SBOX[st_r[127-8*i -: 8]];
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++) sr[4*c+r] = sb[4*((c+r)%4)+r];
    for (int c = 0; c < 4; c++) begin
      mc[4*c]   = aes_pkg::xtime(sr[4*c]) ^ aes_pkg::xtime(sr[4*c+1]) ^ sr[4*c+1]
                  ^ sr[4*c+2] ^ sr[4*c+3];
      mc[4*c+1] = sr[4*c] ^ aes_pkg::xtime(sr[4*c+1]) ^ aes_pkg::xtime(sr[4*c+2])
                  ^ sr[4*c+2] ^ sr[4*c+3];
      mc[4*c+2] = sr[4*c] ^ sr[4*c+1] ^ aes_pkg::xtime(sr[4*c+2])
                  ^ aes_pkg::xtime(sr[4*c+3]) ^ sr[4*c+3];
      mc[4*c+3] = aes_pkg::xtime(sr[4*c]) ^ sr[4*c] ^ sr[4*c+1] ^ sr[4*c+2]
                  ^ aes_pkg::xtime(sr[4*c+3]);
    end
    for (int i = 0; i < 16; i++)
      rnd_out[127-8*i -: 8] = ctl.last ? sr[i] : mc[i];
  end

  always_comb begin
    st_nxt = st_r;
    if (ctl.load) st_nxt = blk_in ^ rkey;
    else if (ctl.step) st_nxt = rnd_out ^ rkey;
  end

  always_ff @(posedge clk) st_r <= st_nxt;
  assign state = st_r;
endmodule

[hw/rtl/aes_block_encrypt_core.sv]
// Channel      | Dir | Payload
// in_          | in  | data_high, data_low (plaintext)
// out_         | out | data_high, data_low (ciphertext)
// cfg_         | in  | index, data
// A block passes through the shared round unit as AddRoundKey and then Nr rounds,
// and its result is held in DONE; one round per cycle with keys made on the fly.
// rst_n synchronously clears the sequencer and key registers.
// in_ready is low while a block is in flight or its result waits on out_ready.
`timescale 1ns / 1ps
module aes_block_encrypt_core (
  input logic clk,
  input logic rst_n,
  aes_blk_if.sink   in_ch,
  aes_blk_if.source out_ch,
  aes_cfg_if.sink   cfg_ch
);
  aes_pkg::state_t state_r, state_nxt;
  logic [1:0]   mode_r;
  logic [255:0] key_r;
  logic [aes_pkg::RND_W-1:0] rnd_r, rnd_nxt;
  logic [aes_pkg::RND_W-1:0] nr;
  aes_pkg::rnd_ctl_t ctl;
  logic [127:0] rkey, st;
  logic in_fire;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready = (state_r == aes_pkg::ST_IDLE);
  assign in_fire = in_ch.valid && in_ch.ready;
  assign out_ch.valid = (state_r == aes_pkg::ST_DONE);
  // round state holds the final block while in DONE
  assign out_ch.data_high = st[127:64];
  assign out_ch.data_low = st[63:0];
  assign nr = (mode_r == aes_pkg::MODE_128) ? 4'd10 :
              (mode_r == aes_pkg::MODE_192) ? 4'd12 : 4'd14;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= '0; key_r <= '0;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        aes_pkg::REG_MODE: mode_r <= cfg_ch.data[1:0];
        aes_pkg::REG_KEY0: key_r[255:192] <= cfg_ch.data;
        aes_pkg::REG_KEY1: key_r[191:128] <= cfg_ch.data;
        aes_pkg::REG_KEY2: key_r[127:64] <= cfg_ch.data;
        aes_pkg::REG_KEY3: key_r[63:0] <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r; rnd_nxt = rnd_r;
    ctl = '0;
    case (state_r)
      aes_pkg::ST_IDLE: if (in_fire) begin
        ctl.load = 1'b1; rnd_nxt = 4'd1; state_nxt = aes_pkg::ST_RUN;
      end
      aes_pkg::ST_RUN: begin
        ctl.step = 1'b1; ctl.last = (rnd_r == nr);
        rnd_nxt = rnd_r + 4'd1;
        if (rnd_r == nr) state_nxt = aes_pkg::ST_DONE;
      end
      aes_pkg::ST_DONE: if (out_ch.ready) state_nxt = aes_pkg::ST_IDLE;
      default: state_nxt = aes_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= aes_pkg::ST_IDLE; rnd_r <= '0;
    end else begin
      state_r <= state_nxt; rnd_r <= rnd_nxt;
    end
  end

  aes_key_sched u_ks (.clk(clk), .mode(mode_r), .key(key_r), .load(ctl.load),
                      .step(ctl.step), .rkey(rkey));
  aes_round u_rnd (.clk(clk), .ctl(ctl), .blk_in({in_ch.data_high, in_ch.data_low}),
                   .rkey(rkey), .state(st));
endmodule

[hw/rtl/aes_block_encrypt_core_chk.sv]
// Port-level checker for the AES core, bound to the top level.
// Depends on aes_block_encrypt_core_assert.svh.
`timescale 1ns / 1ps
`include "aes_block_encrypt_core_assert.svh"
module aes_block_encrypt_core_chk (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready
);
  `AES_ASSERT_IMP(a_no_in_while_out, clk, rst_n, out_valid, !in_ready)
  `AES_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready && !out_valid)
  `AES_ASSERT_NXT(a_out_holds, clk, rst_n, out_valid && !out_ready, out_valid)
endmodule

bind aes_block_encrypt_core aes_block_encrypt_core_chk u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready));
